>>> sv/itp_pkg.sv
package itp_pkg;

  // Default widths for the top level parameters
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int BASE_W   = 6;
  localparam int DIGIT_W  = 7;
  localparam int CCOUNT_W = 16;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // Register index of the base register
  localparam logic [0:0] REG_BASE = 1'b0;

  // Characters the parser looks for
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

  // Digit value marking a byte that is no digit at all
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd64;

  // Radix values fixed by the prefix rules
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [2:0] {
    PH_SIGN       = 3'd0,
    PH_PREFIX     = 3'd1,
    PH_AFTER_ZERO = 3'd2,
    PH_FIRST      = 3'd3,
    PH_DIGITS     = 3'd4,
    PH_OVER       = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Parse control state carried between items
  typedef struct packed {
    phase_t              phase;
    logic [BASE_W-1:0]   ebase;
    logic                neg;
    status_t             status;
  } itp_ctl_t;

  // Digit value of a character, case-insensitive up to 'z'
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] l;
    logic [BYTE_W-1:0] r;
    l = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = c - CH_ZERO;
      digit_of = r[DIGIT_W-1:0];
    end else if (l >= CH_LOW_A && l <= CH_LOW_Z) begin
      r = l - CH_LOW_A + 8'd10;
      digit_of = r[DIGIT_W-1:0];
    end else begin
      digit_of = NOT_DIGIT;
    end
  endfunction

endpackage

>>> sv/itp_step.sv
module itp_step import itp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  itp_ctl_t                 cur_ctl,
  input  logic [VALUE_WIDTH-1:0]   cur_acc,
  input  logic [COUNT_WIDTH-1:0]   cur_cnt,
  input  logic [BASE_W-1:0]        base_reg,
  input  logic                     start_req,
  input  logic [BYTE_W-1:0]        byte_in,
  output itp_ctl_t                 nxt_ctl,
  output logic [VALUE_WIDTH-1:0]   nxt_acc,
  output logic [COUNT_WIDTH-1:0]   nxt_cnt,
  output logic                     took,
  output logic                     finished
);

  localparam int MAC_W = VALUE_WIDTH + DIGIT_W;

  // One byte of the parse: sign and prefix handling, then one multiply-add per digit
  always_comb begin
    itp_ctl_t                 c;
    logic [VALUE_WIDTH-1:0]   acc;
    logic [COUNT_WIDTH-1:0]   cnt;
    logic [DIGIT_W-1:0]       d;
    logic [BASE_W-1:0]        mul_base;
    logic [MAC_W-1:0]         mac;
    logic                     handled;
    logic                     hexable;

    c        = cur_ctl;
    acc      = cur_acc;
    cnt      = cur_cnt;
    d        = digit_of(byte_in);
    took     = 1'b0;
    handled  = 1'b0;
    mac      = '0;
    mul_base = '0;

    if (start_req) begin
      c.phase  = PH_SIGN;
      c.ebase  = base_reg;
      c.neg    = 1'b0;
      c.status = ST_OK;
      acc      = '0;
      cnt      = '0;
    end

    hexable = (c.ebase == BASE_AUTO) || (c.ebase == BASE_HEX);

    // optional sign; status reads "no digits" from here on
    if (c.phase == PH_SIGN) begin
      c.status = ST_EMPTY;
      if (byte_in == CH_PLUS || byte_in == CH_MINUS) begin
        c.neg   = (byte_in == CH_MINUS);
        took    = 1'b1;
        handled = 1'b1;
      end
      c.phase = PH_PREFIX;
    end else if (c.phase == PH_AFTER_ZERO) begin
      if (hexable && ((byte_in | CASE_BIT) == CH_LOW_X)) begin
        c.status = ST_OK;
        c.ebase  = BASE_HEX;
        c.phase  = PH_FIRST;
        took     = 1'b1;
        handled  = 1'b1;
      end else begin
        if (c.ebase == BASE_AUTO) c.ebase = BASE_OCT;
        c.status = ST_OK;
        c.phase  = PH_DIGITS;
      end
    end

    // leading zero may open a hex prefix
    if (!handled && c.phase == PH_PREFIX) begin
      if (byte_in == CH_ZERO && hexable) begin
        c.phase = PH_AFTER_ZERO;
        took    = 1'b1;
        handled = 1'b1;
      end else begin
        if (c.ebase == BASE_AUTO) c.ebase = BASE_DEC;
        c.phase = PH_FIRST;
      end
    end

    if (!handled && c.phase == PH_FIRST) begin
      if (d >= {1'b0, c.ebase}) begin
        c.phase = PH_DONE;
        handled = 1'b1;
      end else begin
        c.status = ST_OK;
        c.phase  = PH_DIGITS;
      end
    end

    // digit: acc*base + d, overflow when the sum leaves the value width
    if (!handled && c.phase == PH_DIGITS) begin
      handled = 1'b1;
      if (d < {1'b0, c.ebase}) begin
        mul_base = (c.ebase == BASE_AUTO) ? 6'd1 : c.ebase;
        mac  = MAC_W'(acc) * MAC_W'(mul_base) + MAC_W'(d);
        took = 1'b1;
        if (|mac[MAC_W-1:VALUE_WIDTH]) begin
          acc      = '1;
          c.status = ST_OVER;
          c.phase  = PH_OVER;
        end else begin
          acc = mac[VALUE_WIDTH-1:0];
        end
      end else begin
        c.phase = PH_DONE;
      end
    end

    // after overflow digits are still taken, value is held
    if (!handled && c.phase == PH_OVER) begin
      if (d < {1'b0, c.ebase}) took = 1'b1;
      else c.phase = PH_DONE;
    end

    if (took && (cnt != '1)) cnt = cnt + COUNT_WIDTH'(1);

    nxt_ctl = c;
    nxt_acc = acc;
    nxt_cnt = cnt;

    unique case (c.phase)
      PH_SIGN, PH_PREFIX, PH_AFTER_ZERO, PH_FIRST, PH_DIGITS, PH_OVER: finished = 1'b0;
      PH_DONE: finished = 1'b1;
      default: finished = 1'b1;
    endcase
  end

endmodule

>>> sv/integer_text_parser.sv
// Pipeline: an accepted item is held in the input register; its result is written
// to the result register when that stage is empty or its result is taken.
// Throughput: one byte per cycle unless out_stall holds the result; the accumulator
// multiply-add and overflow check close a loop through the parse state registers.
// Reset (rst, synchronous): empties both pipeline stages, sets base to 0 and
// puts the parse back to expecting a sign with value, count and status zero.
module integer_text_parser import itp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    start_req,
  input  logic [BYTE_W-1:0]       byte_in,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    consumed,
  output logic                    finished,
  output logic [VALUE_WIDTH-1:0]  value,
  output logic                    negative,
  output logic [1:0]              status,
  output logic [CCOUNT_W-1:0]     consumed_count
);

  logic [BASE_W-1:0]       base;
  logic                    s1_valid;
  logic                    s1_start;
  logic [BYTE_W-1:0]       s1_byte;
  itp_ctl_t                ctl;
  logic [VALUE_WIDTH-1:0]  acc;
  logic [COUNT_WIDTH-1:0]  cnt;
  itp_ctl_t                ctl_next;
  logic [VALUE_WIDTH-1:0]  acc_next;
  logic [COUNT_WIDTH-1:0]  cnt_next;
  logic                    step_took;
  logic                    step_finished;
  logic                    advance;
  logic                    cfg_wr;
  logic [COUNT_WIDTH+CCOUNT_W-1:0] cnt_ext;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1] == REG_BASE) ? PDATA_W'(base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1] == REG_BASE) begin
      base <= pwdata[BASE_W-1:0];
    end
  end

  // Pipeline control: the result stage frees up when empty or taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_start <= start_req;
      s1_byte  <= byte_in;
    end
  end

  itp_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cur_ctl   (ctl),
    .cur_acc   (acc),
    .cur_cnt   (cnt),
    .base_reg  (base),
    .start_req (s1_start),
    .byte_in   (s1_byte),
    .nxt_ctl   (ctl_next),
    .nxt_acc   (acc_next),
    .nxt_cnt   (cnt_next),
    .took      (step_took),
    .finished  (step_finished)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase  <= PH_SIGN;
      ctl.ebase  <= '0;
      ctl.neg    <= 1'b0;
      ctl.status <= ST_OK;
      acc        <= '0;
      cnt        <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  assign cnt_ext = {{CCOUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (advance) begin
      consumed       <= step_took;
      finished       <= step_finished;
      value          <= acc_next;
      negative       <= ctl_next.neg;
      status         <= ctl_next.status;
      consumed_count <= cnt_ext[CCOUNT_W-1:0];
    end
  end

endmodule

>>> sv/itp_checker.sv
module itp_checker import itp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    consumed,
  input logic                    finished,
  input logic [VALUE_WIDTH-1:0]  value,
  input logic [1:0]              status
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("stalled result changed");

  // Overflow always shows a saturated value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVER |-> &value)
    else $error("overflow without saturated value");

  // A consumed byte never ends the parse
  a_took_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && consumed |-> !finished)
    else $error("consumed byte marked finished");

endmodule

bind integer_text_parser itp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_itp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .consumed  (consumed),
  .finished  (finished),
  .value     (value),
  .status    (status)
);

>>> bench/integer_text_parser_tb.sv
`timescale 1ns / 100ps

module integer_text_parser_tb;
  import itp_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_LIMIT  = 3000;
  localparam int GAP_PCT      = 19;
  // no idling on either side while the item count lies from CALM_LO up to CALM_HI
  localparam int CALM_LO      = 700;
  localparam int CALM_HI      = 1100;
  // long hold-off on the result side
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 400;
  localparam logic [PADDR_W-1:0] BASE_ADDR = PADDR_W'(4 * REG_BASE);
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [63:0] VALUE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic       start;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    logic        consumed;
    logic        finished;
    logic [63:0] value;
    logic        negative;
    status_t     status;
    logic [15:0] count;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               start_req = 1'b0;
  logic [BYTE_W-1:0]  byte_in   = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               consumed;
  logic               finished;
  logic [63:0]        value;
  logic               negative;
  logic [1:0]         status;
  logic [CCOUNT_W-1:0] consumed_count;

  // pending text and the parse results still owed by the block
  text_item_t    text_q[$];
  parse_result_t parse_results_q[$];

  int err_count    = 0;
  int bytes_taken  = 0;
  int results_seen = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  int gen_count    = 0;
  bit begin_seq    = 1'b0;

  // register copy and the parse state as the block should hold it
  logic [5:0]  radix_reg = BASE_AUTO;
  phase_t      p_phase   = PH_SIGN;
  logic [5:0]  p_radix   = BASE_AUTO;
  logic [63:0] p_acc     = '0;
  logic        p_neg     = 1'b0;
  status_t     p_status  = ST_OK;
  logic [15:0] p_count   = '0;

  integer_text_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_req      (start_req),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .consumed       (consumed),
    .finished       (finished),
    .value          (value),
    .negative       (negative),
    .status         (status),
    .consumed_count (consumed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // digit weight of a character, 64 for anything that is no digit
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (folded >= CH_LOW_A && folded <= CH_LOW_Z) return 7'(folded - CH_LOW_A + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    logic [7:0] c;
    if (v < 10) begin
      c = CH_ZERO + 8'(v);
    end else begin
      c = CH_LOW_A + 8'(v - 10);
      if ($urandom_range(1)) c = c & ~CASE_BIT;
    end
    return c;
  endfunction

  // one byte through the parser: sign, prefix, digits, overflow, end
  task automatic parse_step(input logic s, input logic [7:0] c, output parse_result_t r);
    logic [6:0]  d;
    logic [63:0] lim;
    bit          took;
    bit          done_here;
    d = char_value(c);
    took = 1'b0;
    done_here = 1'b0;
    if (s) begin
      p_phase  = PH_SIGN;
      p_radix  = radix_reg;
      p_acc    = '0;
      p_neg    = 1'b0;
      p_status = ST_OK;
      p_count  = '0;
    end
    if (p_phase == PH_SIGN) begin
      p_status = ST_EMPTY;
      if (c == CH_PLUS || c == CH_MINUS) begin
        p_neg = (c == CH_MINUS);
        took = 1'b1;
        done_here = 1'b1;
      end
      p_phase = PH_PREFIX;
    end else if (p_phase == PH_AFTER_ZERO) begin
      if ((p_radix == BASE_AUTO || p_radix == BASE_HEX) && (c | CASE_BIT) == CH_LOW_X) begin
        p_status = ST_OK;
        p_radix = BASE_HEX;
        p_phase = PH_FIRST;
        took = 1'b1;
        done_here = 1'b1;
      end else begin
        if (p_radix == BASE_AUTO) p_radix = BASE_OCT;
        p_status = ST_OK;
        p_phase = PH_DIGITS;
      end
    end
    // a leading zero may open a hex prefix
    if (!done_here && p_phase == PH_PREFIX) begin
      if (c == CH_ZERO && (p_radix == BASE_AUTO || p_radix == BASE_HEX)) begin
        p_phase = PH_AFTER_ZERO;
        took = 1'b1;
        done_here = 1'b1;
      end else begin
        if (p_radix == BASE_AUTO) p_radix = BASE_DEC;
        p_phase = PH_FIRST;
      end
    end
    if (!done_here && p_phase == PH_FIRST) begin
      if (d >= p_radix) begin
        p_phase = PH_DONE;
        done_here = 1'b1;
      end else begin
        p_status = ST_OK;
        p_phase = PH_DIGITS;
      end
    end
    // multiply-add, saturating on overflow
    if (!done_here && p_phase == PH_DIGITS) begin
      done_here = 1'b1;
      if (d < p_radix) begin
        took = 1'b1;
        lim = (VALUE_MAX - {57'b0, d}) / {58'b0, p_radix};
        if (p_acc > lim) begin
          p_acc = VALUE_MAX;
          p_status = ST_OVER;
          p_phase = PH_OVER;
        end else begin
          p_acc = p_acc * {58'b0, p_radix} + {57'b0, d};
        end
      end else begin
        p_phase = PH_DONE;
      end
    end
    if (!done_here && p_phase == PH_OVER) begin
      if (d < p_radix) took = 1'b1;
      else p_phase = PH_DONE;
    end
    if (took && p_count != COUNT_MAX) p_count = p_count + 16'd1;
    r.consumed = took;
    r.finished = (p_phase == PH_DONE);
    r.value    = p_acc;
    r.negative = p_neg;
    r.status   = p_status;
    r.count    = p_count;
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    err_count++;
    $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
  endtask

  // queue one byte; the first byte of a sequence carries the start flag
  task automatic push_ch(input logic [7:0] c);
    text_item_t it;
    it.start = begin_seq;
    it.ch = c;
    begin_seq = 1'b0;
    text_q.push_back(it);
    gen_count++;
  endtask

  task automatic push_text(input string s, input bit fresh);
    begin_seq = fresh;
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  // a well-formed number for the given radix, now and then with a bad byte
  task automatic push_number(input logic [5:0] radix);
    int         eff;
    int         top;
    int         n;
    int         v;
    bit         long_run;
    logic [7:0] term;
    text_item_t junk;
    begin_seq = 1'b1;
    case ($urandom_range(2))
      1: push_ch(CH_PLUS);
      2: push_ch(CH_MINUS);
      default: ;
    endcase
    eff = radix;
    long_run = ($urandom_range(99) < 15);
    n = long_run ? $urandom_range(20, 70) : $urandom_range(0, 8);
    if (radix == BASE_AUTO) begin
      case ($urandom_range(2))
        0: begin
          push_ch(CH_ZERO);
          push_ch($urandom_range(1) ? CH_LOW_X : (CH_LOW_X & ~CASE_BIT));
          eff = BASE_HEX;
        end
        1: begin
          push_ch(CH_ZERO);
          eff = BASE_OCT;
        end
        default: begin
          push_ch(digit_char($urandom_range(1, 9)));
          eff = BASE_DEC;
        end
      endcase
    end else if (radix == BASE_HEX && $urandom_range(1)) begin
      push_ch(CH_ZERO);
      push_ch(CH_LOW_X);
    end
    top = (eff > 36) ? 36 : eff;
    for (int i = 0; i < n; i++) begin
      v = (long_run && $urandom_range(1)) ? top - 1 : $urandom_range(top - 1);
      if ($urandom_range(99) < 3) push_ch(8'($urandom_range(255)));
      else push_ch(digit_char(v));
    end
    if ($urandom_range(99) < 85) begin
      do term = 8'($urandom_range(255)); while (char_value(term) < top);
      push_ch(term);
      // trailing bytes the finished parse ignores
      repeat ($urandom_range(2)) begin
        junk.start = 1'b0;
        junk.ch = 8'($urandom_range(255));
        text_q.push_back(junk);
      end
    end
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 5)) begin
      begin_seq = ($urandom_range(3) == 0);
      push_ch(8'($urandom_range(255)));
    end
  endtask

  // wait until all text has gone in and every result has come out
  task automatic drain();
    do @(negedge clk);
    while (text_q.size() != 0 || in_valid || parse_results_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // base register write followed by a read back
  task automatic write_base(input logic [5:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BASE_ADDR;
    pwdata <= {26'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radix_reg = v;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {26'b0, radix_reg}) flag_mismatch("prdata", {26'b0, radix_reg}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    text_item_t    nxt;
    parse_result_t r;
    bit            gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_step(start_req, byte_in, r);
        parse_results_q.push_back(r);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        gap = !(bytes_taken >= CALM_LO && bytes_taken < CALM_HI) &&
              ($urandom_range(99) < GAP_PCT);
        if (text_q.size() != 0 && !gap) begin
          nxt = text_q.pop_front();
          in_valid <= 1'b1;
          start_req <= nxt.start;
          byte_in <= nxt.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    parse_result_t want;
    bit            calm;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_results_q.size() == 0) begin
          err_count++;
          $error("result with no item outstanding: value 'h%0h", value);
        end else begin
          want = parse_results_q.pop_front();
          if (consumed !== want.consumed) flag_mismatch("consumed", want.consumed, consumed);
          if (finished !== want.finished) flag_mismatch("finished", want.finished, finished);
          if (value !== want.value) flag_mismatch("value", want.value, value);
          if (negative !== want.negative) flag_mismatch("negative", want.negative, negative);
          if (status !== want.status) flag_mismatch("status", want.status, status);
          if (consumed_count !== want.count)
            flag_mismatch("consumed_count", want.count, consumed_count);
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      calm = (results_seen >= CALM_LO && results_seen < CALM_HI);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < GAP_PCT);
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [5:0] notable [9];
    int         phase_end;
    notable = '{BASE_AUTO, 6'd1, 6'd2, BASE_OCT, BASE_DEC, BASE_HEX, 6'd36, 6'd37, 6'd63};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // detected radix: sign, hex and octal prefixes, lone zero, prefix only
    push_text("+0x1F;", 1);
    push_text("-017 ", 1);
    push_text("09", 1);
    push_text("0Xg", 1);
    // largest value and one past it
    push_text("18446744073709551615 ", 1);
    push_text("18446744073709551616 ", 1);
    // no digits at all, byte extremes
    push_text(".", 1);
    push_text("-z", 1);
    begin_seq = 1'b1;
    push_ch(8'h00);
    begin_seq = 1'b1;
    push_ch(8'hFF);
    // left mid-parse across a register write: radix stays decimal
    push_text("12", 1);
    drain();
    write_base(BASE_HEX);
    push_text("34 ", 0);
    push_text("0xFFFFFFFFFFFFFFFF ", 1);
    push_text("10000000000000000 ", 1);
    drain();
    write_base(6'd36);
    push_text("Zz.", 1);
    push_text("3w5e11264sgsg ", 1);
    drain();
    write_base(6'd1);
    push_text("001 ", 1);
    drain();
    write_base(6'd63);
    push_text("zZ9!", 1);
    drain();

    // random phases, each under its own radix
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 50) write_base(notable[$urandom_range(8)]);
      else write_base(6'($urandom_range(63)));
      phase_end = gen_count + $urandom_range(60, 200);
      while (gen_count < phase_end) begin
        if ($urandom_range(99) < 80) push_number(radix_reg);
        else push_noise();
      end
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
